// File: hdl/barometric_pressure_compensation_core_assert.svh
// Assertion macros for the barometric pressure compensation core.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BPC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bpc_pkg.sv
// Shared types, constants and the divider step for the pressure compensation core.
// No dependencies.
package bpc_pkg;

   localparam int DIV_STEPS = 32;

   localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
   localparam logic [31:0]        B4_BIAS   = 32'd32768;
   localparam logic [31:0]        B7_SCALE  = 32'd50000;
   localparam logic signed [31:0] P_C1      = 32'sd3038;
   localparam logic signed [31:0] P_C2      = -32'sd7357;
   localparam logic signed [31:0] P_C3      = 32'sd3791;

   typedef enum logic [1:0] {
      CSR_COEF_A  = 2'd0,
      CSR_COEF_B  = 2'd1,
      CSR_COEF_C  = 2'd2,
      CSR_COEF_MD = 2'd3
   } csr_index_type;

   // sideband that rides along with a divider transaction
   typedef struct packed {
      logic               err;
      logic               neg;
      logic               pre;
      logic [15:0]        up;
      logic signed [31:0] x1;
      logic signed [31:0] t;
   } side_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] nq;
   } div_step_type;

   // one restoring step: numerator bits leave nq at the top, quotient bits enter at the bottom
   function automatic div_step_type div_step(input logic [31:0] rem,
                                             input logic [31:0] nq,
                                             input logic [31:0] den);
      div_step_type r;
      logic [32:0]  part;
      logic [32:0]  diff;
      logic         ge;
      part  = {rem, nq[31]};
      diff  = part - {1'b0, den};
      ge    = (part >= {1'b0, den});
      r.rem = ge ? diff[31:0] : part[31:0];
      r.nq  = {nq[30:0], ge};
      return r;
   endfunction

endpackage

// File: hdl/bpc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg (side_type, div_step, DIV_STEPS).
module bpc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [31:0]       in_num,
   input  logic [31:0]       in_den,
   input  bpc_pkg::side_type in_side,
   output logic              out_valid,
   output logic [31:0]       out_quo,
   output bpc_pkg::side_type out_side
);
   import bpc_pkg::*;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [31:0]          rem_ff  [DIV_STEPS];
   logic [31:0]          nq_ff   [DIV_STEPS];
   logic [31:0]          den_ff  [DIV_STEPS];
   side_type             side_ff [DIV_STEPS];
   div_step_type         step_in [DIV_STEPS];

   always_comb begin
      step_in[0] = div_step('0, in_num, in_den);
      for (int i = 1; i < DIV_STEPS; i++) begin
         step_in[i] = div_step(rem_ff[i-1], nq_ff[i-1], den_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= step_in[0].rem;
         nq_ff[0]   <= step_in[0].nq;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int i = 1; i < DIV_STEPS; i++) begin
            rem_ff[i]  <= step_in[i].rem;
            nq_ff[i]   <= step_in[i].nq;
            den_ff[i]  <= den_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quo   = nq_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

// File: hdl/barometric_pressure_compensation_core.sv
// Barometer temperature/pressure compensation (oversampling zero), top level.
// Depends on bpc_pkg, bpc_div and barometric_pressure_compensation_core_assert.svh.
//
// Takes one raw temperature/pressure pair per transaction and returns temperature in
// 0.1 C and pressure in Pa, with div_error set (and both values zero) when a divisor
// is zero. Fully pipelined: one transaction per cycle sustained while the result side
// does not stall. The result passes through 74 register stages: the two 32-stage
// restoring dividers (the temperature term and the pressure quotient) plus ten
// arithmetic stages around them. A stall on the result side freezes the whole
// pipe. Coefficients are written through the csr port and must only change while the
// pipe is empty.
module barometric_pressure_compensation_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_raw_temp,
   input  logic [15:0]        req_raw_press,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_temp_tenths,
   output logic signed [31:0] rsp_press_pa,
   output logic               rsp_div_error,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_wdata
);
   import bpc_pkg::*;

   `include "barometric_pressure_compensation_core_assert.svh"

   // ---------------- configuration ----------------
   logic [47:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [15:0] coef_md_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= '0;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_md_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_A:  coef_a_ff  <= csr_wdata;
            CSR_COEF_B:  coef_b_ff  <= csr_wdata;
            CSR_COEF_C:  coef_c_ff  <= csr_wdata;
            CSR_COEF_MD: coef_md_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = 32'(signed'(coef_a_ff[15:0]));
   assign ac2 = 32'(signed'(coef_a_ff[31:16]));
   assign ac3 = 32'(signed'(coef_a_ff[47:32]));
   assign ac4 = coef_b_ff[15:0];
   assign ac5 = coef_b_ff[31:16];
   assign ac6 = coef_b_ff[47:32];
   assign b1  = 32'(signed'(coef_c_ff[15:0]));
   assign b2  = 32'(signed'(coef_c_ff[31:16]));
   assign mc  = 32'(signed'(coef_c_ff[47:32]));
   assign md  = 32'(signed'(coef_md_ff));

   // whole pipe advances together
   logic pipe_en;
   logic rsp_valid_ff;
   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   // ---------------- stage 1: x1 = ((ut - ac6) * ac5) >> 15 ----------------
   logic signed [17:0] s1_diff;
   logic signed [34:0] s1_prod;
   logic signed [31:0] s1_x1;
   logic               s1_valid_ff;
   logic signed [31:0] s1_x1_ff;
   logic [15:0]        s1_up_ff;

   assign s1_diff = $signed({2'b00, req_raw_temp}) - $signed({2'b00, ac6});
   assign s1_prod = s1_diff * $signed({1'b0, ac5});
   assign s1_x1   = $signed(s1_prod[31:0]) >>> 15;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x1_ff <= s1_x1;
         s1_up_ff <= req_raw_press;
      end
   end

   // ---------------- stage 2: divider operands for mc*2048 / (x1+md) ----------------
   logic signed [31:0] s2_den, s2_dividend;
   side_type           s2_side_in;
   logic               s2_valid_ff;
   logic [31:0]        s2_num_ff, s2_den_ff;
   side_type           s2_side_ff;

   assign s2_den      = s1_x1_ff + md;
   assign s2_dividend = mc <<< 11;

   always_comb begin
      s2_side_in     = '0;
      s2_side_in.err = (s2_den == 32'sd0);
      s2_side_in.neg = s2_dividend[31] ^ s2_den[31];
      s2_side_in.up  = s1_up_ff;
      s2_side_in.x1  = s1_x1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_num_ff  <= s2_dividend[31] ? 32'(-s2_dividend) : 32'(s2_dividend);
         s2_den_ff  <= s2_den[31] ? 32'(-s2_den) : 32'(s2_den);
         s2_side_ff <= s2_side_in;
      end
   end

   logic        d1_valid;
   logic [31:0] d1_quo;
   side_type    d1_side;

   bpc_div u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .enable   (pipe_en),
      .in_valid (s2_valid_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_side  (s2_side_ff),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // ---------------- stage 3: b5, t, b6 ----------------
   logic signed [31:0] s3_x2, s3_b5, s3_sum8;
   logic               s3_valid_ff;
   logic signed [31:0] s3_b6_ff, s3_t_ff;
   logic               s3_err_ff;
   logic [15:0]        s3_up_ff;

   assign s3_x2   = d1_side.neg ? -$signed(d1_quo) : $signed(d1_quo);
   assign s3_b5   = d1_side.x1 + s3_x2;
   assign s3_sum8 = s3_b5 + 32'sd8;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_b6_ff  <= s3_b5 - B6_OFFSET;
         s3_t_ff   <= s3_sum8 >>> 4;
         s3_err_ff <= d1_side.err;
         s3_up_ff  <= d1_side.up;
      end
   end

   // ---------------- stage 4: sq, ac2*b6, ac3*b6 ----------------
   logic signed [63:0] s4_sq_p, s4_x2a_p, s4_x1c_p;
   logic               s4_valid_ff;
   logic signed [31:0] s4_sq_ff, s4_x2a_ff, s4_x1c_ff, s4_t_ff;
   logic               s4_err_ff;
   logic [15:0]        s4_up_ff;

   assign s4_sq_p  = s3_b6_ff * s3_b6_ff;
   assign s4_x2a_p = ac2 * s3_b6_ff;
   assign s4_x1c_p = ac3 * s3_b6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_sq_ff  <= $signed(s4_sq_p[31:0]) >>> 12;
         s4_x2a_ff <= $signed(s4_x2a_p[31:0]) >>> 11;
         s4_x1c_ff <= $signed(s4_x1c_p[31:0]) >>> 13;
         s4_t_ff   <= s3_t_ff;
         s4_err_ff <= s3_err_ff;
         s4_up_ff  <= s3_up_ff;
      end
   end

   // ---------------- stage 5: b2*sq, b1*sq ----------------
   logic signed [63:0] s5_x1_p, s5_x2b_p;
   logic               s5_valid_ff;
   logic signed [31:0] s5_x1_ff, s5_x2b_ff, s5_x2a_ff, s5_x1c_ff, s5_t_ff;
   logic               s5_err_ff;
   logic [15:0]        s5_up_ff;

   assign s5_x1_p  = b2 * s4_sq_ff;
   assign s5_x2b_p = b1 * s4_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_x1_ff  <= $signed(s5_x1_p[31:0]) >>> 11;
         s5_x2b_ff <= $signed(s5_x2b_p[31:0]) >>> 16;
         s5_x2a_ff <= s4_x2a_ff;
         s5_x1c_ff <= s4_x1c_ff;
         s5_t_ff   <= s4_t_ff;
         s5_err_ff <= s4_err_ff;
         s5_up_ff  <= s4_up_ff;
      end
   end

   // ---------------- stage 6: b3 and x3 ----------------
   logic signed [31:0] s6_b3_sum, s6_x3_sum;
   logic signed [33:0] s6_b3_ext;
   logic signed [33:0] s6_b3_q;
   logic               s6_valid_ff;
   logic signed [31:0] s6_b3_ff, s6_x3_ff, s6_t_ff;
   logic               s6_err_ff;
   logic [15:0]        s6_up_ff;

   assign s6_b3_sum = (ac1 <<< 2) + s5_x1_ff + s5_x2a_ff + 32'sd2;
   // divide by 4 truncating toward zero
   assign s6_b3_ext = 34'(s6_b3_sum) + (s6_b3_sum[31] ? 34'sd3 : 34'sd0);
   assign s6_b3_q   = s6_b3_ext >>> 2;
   assign s6_x3_sum = s5_x1c_ff + s5_x2b_ff + 32'sd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s6_b3_ff  <= s6_b3_q[31:0];
         s6_x3_ff  <= s6_x3_sum >>> 2;
         s6_t_ff   <= s5_t_ff;
         s6_err_ff <= s5_err_ff;
         s6_up_ff  <= s5_up_ff;
      end
   end

   // ---------------- stage 7: b4 and b7 ----------------
   logic [47:0]        s7_b4_p;
   logic [47:0]        s7_b7_p;
   logic [31:0]        s7_b4_opnd, s7_b7_opnd;
   logic               s7_valid_ff;
   logic [31:0]        s7_b4_ff, s7_b7_ff;
   logic signed [31:0] s7_t_ff;
   logic               s7_err_ff;

   assign s7_b4_opnd = s6_x3_ff + B4_BIAS;
   assign s7_b4_p    = {16'd0, ac4} * {16'd0, s7_b4_opnd};
   assign s7_b7_opnd = {16'd0, s6_up_ff} - s6_b3_ff;
   assign s7_b7_p    = {16'd0, s7_b7_opnd} * {16'd0, B7_SCALE};

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s7_b4_ff  <= {15'd0, s7_b4_p[31:15]};
         s7_b7_ff  <= s7_b7_p[31:0];
         s7_t_ff   <= s6_t_ff;
         s7_err_ff <= s6_err_ff;
      end
   end

   // ---------------- stage 8: pressure divide b7 / b4 ----------------
   side_type    s8_side;
   logic [31:0] s8_num;

   always_comb begin
      s8_side     = '0;
      s8_side.err = s7_err_ff || (s7_b4_ff == 32'd0);
      s8_side.pre = !s7_b7_ff[31];
      s8_side.t   = s7_t_ff;
   end

   // below 2^31 the numerator is doubled first, otherwise the quotient is doubled
   assign s8_num = s7_b7_ff[31] ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0};

   logic        d2_valid;
   logic [31:0] d2_quo;
   side_type    d2_side;

   bpc_div u_div_press (
      .clock    (clock),
      .reset    (reset),
      .enable   (pipe_en),
      .in_valid (s7_valid_ff),
      .in_num   (s8_num),
      .in_den   (s7_b4_ff),
      .in_side  (s8_side),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // ---------------- stage 9: p, (p>>8)^2, -7357*p ----------------
   logic signed [31:0] s9_p, s9_ps;
   logic signed [63:0] s9_sq_p, s9_x2_p;
   logic               s9_valid_ff;
   logic signed [31:0] s9_p_ff, s9_x1_ff, s9_x2_ff, s9_t_ff;
   logic               s9_err_ff;

   assign s9_p    = d2_side.pre ? $signed(d2_quo) : $signed({d2_quo[30:0], 1'b0});
   assign s9_ps   = s9_p >>> 8;
   assign s9_sq_p = s9_ps * s9_ps;
   assign s9_x2_p = P_C2 * s9_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s9_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s9_p_ff   <= s9_p;
         s9_x1_ff  <= $signed(s9_sq_p[31:0]);
         s9_x2_ff  <= $signed(s9_x2_p[31:0]) >>> 16;
         s9_t_ff   <= d2_side.t;
         s9_err_ff <= d2_side.err;
      end
   end

   // ---------------- stage 10: x1 * 3038 ----------------
   logic signed [63:0] s10_x1_p;
   logic               s10_valid_ff;
   logic signed [31:0] s10_p_ff, s10_x1_ff, s10_x2_ff, s10_t_ff;
   logic               s10_err_ff;

   assign s10_x1_p = s9_x1_ff * P_C1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s10_x1_ff  <= $signed(s10_x1_p[31:0]) >>> 16;
         s10_p_ff   <= s9_p_ff;
         s10_x2_ff  <= s9_x2_ff;
         s10_t_ff   <= s9_t_ff;
         s10_err_ff <= s9_err_ff;
      end
   end

   // ---------------- output register ----------------
   logic signed [31:0] out_corr, out_press;
   logic signed [31:0] rsp_temp_ff, rsp_press_ff;
   logic               rsp_err_ff;

   assign out_corr  = s10_x1_ff + s10_x2_ff + P_C3;
   assign out_press = s10_p_ff + (out_corr >>> 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_temp_ff  <= s10_err_ff ? 32'sd0 : s10_t_ff;
         rsp_press_ff <= s10_err_ff ? 32'sd0 : out_press;
         rsp_err_ff   <= s10_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_tenths = rsp_temp_ff;
   assign rsp_press_pa    = rsp_press_ff;
   assign rsp_div_error   = rsp_err_ff;

   // ---------------- assertions ----------------
   `BPC_ASSERT_IMP(a_err_zeroes, clock, reset, rsp_valid_ff && rsp_err_ff,
      rsp_temp_ff == 32'sd0 && rsp_press_ff == 32'sd0, "error result carries nonzero values")
   `BPC_ASSERT_IMP(a_stall_backs_up, clock, reset, rsp_valid_ff && rsp_stall,
      req_stall, "input taken while output is blocked")
   `BPC_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && !req_stall,
      s1_valid_ff, "accepted transaction missing from first stage")

endmodule
